[sv/assert_macros.svh]
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is held.
`define SGMD_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define SGMD_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/sgmd_pkg.sv]
package sgmd_pkg;

    // Packet framing limits
    localparam logic [7:0]  MaxPacket   = 8'd128;
    localparam logic [7:0]  MinPacket   = 8'd10;
    localparam logic [14:0] LenMinBad   = 15'd4;
    localparam logic [14:0] LenReserved = 15'h7FFF;
    localparam logic [7:0]  FirstReport = 8'd4;
    localparam logic [7:0]  IndexMax    = 8'd255;
    localparam logic [8:0]  TsReportLen = 9'd5;
    localparam logic [8:0]  GyroLastOff = 9'd6;

    // Header byte positions
    localparam logic [7:0] HdrLenHigh = 8'd1;
    localparam logic [7:0] HdrChannel = 8'd2;
    localparam logic [7:0] HdrSeq     = 8'd3;

    // Gyro report byte offsets
    localparam logic [7:0] OffXLow  = 8'd3;
    localparam logic [7:0] OffXHigh = 8'd4;
    localparam logic [7:0] OffYLow  = 8'd5;
    localparam logic [7:0] OffYHigh = 8'd6;

    // Register reset values
    localparam logic [3:0]  SensReset     = 4'd5;
    localparam logic [14:0] DeadbandReset = 15'd26;
    localparam logic [7:0]  ChannelReset  = 8'd3;
    localparam logic [7:0]  GyroIdReset   = 8'd2;
    localparam logic [7:0]  TsIdReset     = 8'hFB;

    // Saturation limits of one delta
    localparam logic [7:0] DeltaPosMax = 8'h7F;
    localparam logic [7:0] DeltaNegMax = 8'h81;

    typedef enum logic [2:0] {
        REG_SENS_X   = 3'd0,
        REG_SENS_Y   = 3'd1,
        REG_DEADBAND = 3'd2,
        REG_CHANNEL  = 3'd3,
        REG_GYRO_ID  = 3'd4,
        REG_TS_ID    = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [3:0]  sens_x;
        logic [3:0]  sens_y;
        logic [14:0] deadband_raw;
        logic [7:0]  input_channel;
        logic [7:0]  gyro_report_id;
        logic [7:0]  timestamp_report_id;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
    } sample_t;

endpackage

[sv/sgmd_cfg.sv]
module sgmd_cfg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [2:0]       cfg_addr,
    input  logic [14:0]      cfg_data,
    output sgmd_pkg::cfg_t   cfg
);

    sgmd_pkg::cfg_t cfg_reg;
    sgmd_pkg::cfg_t cfg_next;

    // Decode the register index and merge the written field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                sgmd_pkg::REG_SENS_X:   cfg_next.sens_x              = cfg_data[3:0];
                sgmd_pkg::REG_SENS_Y:   cfg_next.sens_y              = cfg_data[3:0];
                sgmd_pkg::REG_DEADBAND: cfg_next.deadband_raw        = cfg_data;
                sgmd_pkg::REG_CHANNEL:  cfg_next.input_channel       = cfg_data[7:0];
                sgmd_pkg::REG_GYRO_ID:  cfg_next.gyro_report_id      = cfg_data[7:0];
                sgmd_pkg::REG_TS_ID:    cfg_next.timestamp_report_id = cfg_data[7:0];
                default:                cfg_next                     = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sens_x              <= sgmd_pkg::SensReset;
            cfg_reg.sens_y              <= sgmd_pkg::SensReset;
            cfg_reg.deadband_raw        <= sgmd_pkg::DeadbandReset;
            cfg_reg.input_channel       <= sgmd_pkg::ChannelReset;
            cfg_reg.gyro_report_id      <= sgmd_pkg::GyroIdReset;
            cfg_reg.timestamp_report_id <= sgmd_pkg::TsIdReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/sgmd_parser.sv]
module sgmd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                first_byte,
    input  sgmd_pkg::cfg_t      cfg,
    output sgmd_pkg::sample_t   sample
);

    logic [7:0]  byte_index_reg,      byte_index_next;
    logic [7:0]  packet_length_reg,   packet_length_next;
    logic [7:0]  length_low_byte_reg, length_low_byte_next;
    logic        packet_active_reg,   packet_active_next;
    logic [7:0]  next_report_pos_reg, next_report_pos_next;
    logic        in_gyro_report_reg,  in_gyro_report_next;
    logic [15:0] raw_x_value_reg,     raw_x_value_next;
    logic [7:0]  raw_y_low_reg,       raw_y_low_next;

    logic [14:0] len_raw;
    logic [7:0]  len_clamped;
    logic [7:0]  report_off;
    logic [8:0]  ts_end;
    logic [8:0]  gyro_end;

    // Header length, report offset and report end positions
    always_comb
    begin
        len_raw     = {data_byte[6:0], length_low_byte_reg};
        len_clamped = (len_raw > {7'd0, sgmd_pkg::MaxPacket}) ? sgmd_pkg::MaxPacket
                                                              : len_raw[7:0];
        report_off  = byte_index_reg - next_report_pos_reg;
        ts_end      = {1'b0, next_report_pos_reg} + sgmd_pkg::TsReportLen;
        gyro_end    = {1'b0, byte_index_reg} + sgmd_pkg::GyroLastOff;
    end

    // Advance the packet scan by one byte
    always_comb
    begin
        byte_index_next      = byte_index_reg;
        packet_length_next   = packet_length_reg;
        length_low_byte_next = length_low_byte_reg;
        packet_active_next   = packet_active_reg;
        next_report_pos_next = next_report_pos_reg;
        in_gyro_report_next  = in_gyro_report_reg;
        raw_x_value_next     = raw_x_value_reg;
        raw_y_low_next       = raw_y_low_reg;
        sample.valid         = 1'b0;
        sample.raw_x         = raw_x_value_reg;
        sample.raw_y         = {data_byte, raw_y_low_reg};

        if (step)
        begin
            if (first_byte)
            begin
                length_low_byte_next = data_byte;
                byte_index_next      = 8'd1;
                packet_active_next   = 1'b1;
                next_report_pos_next = sgmd_pkg::FirstReport;
                in_gyro_report_next  = 1'b0;
                packet_length_next   = 8'd0;
            end
            else if (packet_active_reg)
            begin
                if (byte_index_reg != sgmd_pkg::IndexMax)
                begin
                    byte_index_next = byte_index_reg + 8'd1;
                end

                priority if (byte_index_reg == sgmd_pkg::HdrLenHigh)
                begin
                    if (len_raw <= sgmd_pkg::LenMinBad || len_raw == sgmd_pkg::LenReserved
                        || len_clamped < sgmd_pkg::MinPacket)
                    begin
                        packet_active_next = 1'b0;
                    end
                    else
                    begin
                        packet_length_next = len_clamped;
                    end
                end
                else if (byte_index_reg == sgmd_pkg::HdrChannel)
                begin
                    if (data_byte != cfg.input_channel)
                    begin
                        packet_active_next = 1'b0;
                    end
                end
                else if (byte_index_reg == sgmd_pkg::HdrSeq)
                begin
                    packet_active_next = packet_active_reg;
                end
                else if (byte_index_reg >= packet_length_reg)
                begin
                    packet_active_next = 1'b0;
                end
                else if (!in_gyro_report_reg)
                begin
                    // Look at the report id at the head of each report
                    if (byte_index_reg == next_report_pos_reg)
                    begin
                        priority if (data_byte == cfg.timestamp_report_id)
                        begin
                            if (ts_end >= {1'b0, packet_length_reg})
                            begin
                                packet_active_next = 1'b0;
                            end
                            else
                            begin
                                next_report_pos_next = ts_end[7:0];
                            end
                        end
                        else if (data_byte == cfg.gyro_report_id)
                        begin
                            if (gyro_end >= {1'b0, packet_length_reg})
                            begin
                                packet_active_next = 1'b0;
                            end
                            else
                            begin
                                in_gyro_report_next = 1'b1;
                            end
                        end
                        else
                        begin
                            packet_active_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    // Collect the gyro axes, little endian
                    priority if (report_off == sgmd_pkg::OffXLow)
                    begin
                        raw_x_value_next = {8'd0, data_byte};
                    end
                    else if (report_off == sgmd_pkg::OffXHigh)
                    begin
                        raw_x_value_next = {data_byte, raw_x_value_reg[7:0]};
                    end
                    else if (report_off == sgmd_pkg::OffYLow)
                    begin
                        raw_y_low_next = data_byte;
                    end
                    else if (report_off == sgmd_pkg::OffYHigh)
                    begin
                        sample.valid        = 1'b1;
                        in_gyro_report_next = 1'b0;
                        packet_active_next  = 1'b0;
                    end
                    else
                    begin
                        in_gyro_report_next = in_gyro_report_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg      <= 8'd0;
            packet_length_reg   <= 8'd0;
            length_low_byte_reg <= 8'd0;
            packet_active_reg   <= 1'b0;
            next_report_pos_reg <= sgmd_pkg::FirstReport;
            in_gyro_report_reg  <= 1'b0;
            raw_x_value_reg     <= 16'd0;
            raw_y_low_reg       <= 8'd0;
        end
        else
        begin
            byte_index_reg      <= byte_index_next;
            packet_length_reg   <= packet_length_next;
            length_low_byte_reg <= length_low_byte_next;
            packet_active_reg   <= packet_active_next;
            next_report_pos_reg <= next_report_pos_next;
            in_gyro_report_reg  <= in_gyro_report_next;
            raw_x_value_reg     <= raw_x_value_next;
            raw_y_low_reg       <= raw_y_low_next;
        end
    end

endmodule

[sv/sgmd_scale.sv]
module sgmd_scale
(
    input  logic [15:0] raw,
    input  logic [3:0]  sens,
    input  logic [14:0] deadband,
    output logic [7:0]  delta
);

    logic        [16:0] mag;
    logic signed [20:0] prod;
    logic signed [20:0] biased;
    logic signed [11:0] quot;

    // Scale by sens/512, rounding toward zero
    always_comb
    begin
        mag    = raw[15] ? (17'd0 - {raw[15], raw}) : {1'b0, raw};
        prod   = $signed({{5{raw[15]}}, raw}) * $signed({17'd0, sens});
        biased = prod + (prod[20] ? 21'sd511 : 21'sd0);
        quot   = biased[20:9];
    end

    // Apply the deadband, then saturate
    always_comb
    begin
        priority if (mag < {2'b00, deadband})
        begin
            delta = 8'd0;
        end
        else if (quot > 12'sd127)
        begin
            delta = sgmd_pkg::DeltaPosMax;
        end
        else if (quot < -12'sd127)
        begin
            delta = sgmd_pkg::DeltaNegMax;
        end
        else
        begin
            delta = quot[7:0];
        end
    end

endmodule

[sv/shtp_gyro_report_to_mouse_delta_unit.sv]
// Sensor-hub packet parser that turns the first gyro report of each packet on the
// selected channel into one mouse movement beat. Packet bytes enter one per beat,
// with s_tuser set on header byte 0. A new byte may follow in every cycle, and only
// a stalled result beat slows the input. The Y high byte is held in the input
// register and its result in the result register. A result holds X and Y deltas,
// each the raw axis scaled by sens/512 toward zero, zeroed below the deadband and
// held within +-127, plus a flag set when either delta is nonzero. Registers are
// written on the cfg channel (0 sens_x, 1 sens_y, 2 deadband_raw, 3 input_channel,
// 4 gyro_report_id, 5 timestamp_report_id); the user must write them only while no
// packet is in flight, which the block itself does not enforce.
`include "assert_macros.svh"

module shtp_gyro_report_to_mouse_delta_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [14:0] cfg_data,
    // packet byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] first_byte
    // movement result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] delta_x, [15:8] delta_y
    output logic        m_tuser    // [0] send_report
);

    sgmd_pkg::cfg_t    cfg;
    sgmd_pkg::sample_t sample;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg,  s1_byte_next;
    logic       s1_first_reg, s1_first_next;
    logic       m_valid_reg,  m_valid_next;
    logic [7:0] dx_reg,       dx_next;
    logic [7:0] dy_reg,       dy_next;
    logic       send_reg,     send_next;

    logic       out_free;
    logic       step;
    logic [7:0] dx;
    logic [7:0] dy;

    assign cfg_ready = 1'b1;

    sgmd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held byte on whenever the result register can take a beat
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign step     = s1_valid_reg && out_free;

    sgmd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (s1_byte_reg),
        .first_byte (s1_first_reg),
        .cfg        (cfg),
        .sample     (sample)
    );

    sgmd_scale u_scale_x
    (
        .raw      (sample.raw_x),
        .sens     (cfg.sens_x),
        .deadband (cfg.deadband_raw),
        .delta    (dx)
    );

    sgmd_scale u_scale_y
    (
        .raw      (sample.raw_y),
        .sens     (cfg.sens_y),
        .deadband (cfg.deadband_raw),
        .delta    (dy)
    );

    // Input register: load a beat when it is empty or the held one leaves
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_byte_next  = s1_byte_reg;
        s1_first_next = s1_first_reg;
        if (s_tready)
        begin
            s1_valid_next = s_tvalid;
            s1_byte_next  = s_tdata;
            s1_first_next = s_tuser;
        end
    end

    // Result register: load a finished sample, drop a taken beat
    always_comb
    begin
        m_valid_next = m_valid_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        send_next    = send_reg;
        if (out_free)
        begin
            m_valid_next = sample.valid;
            dx_next      = dx;
            dy_next      = dy;
            send_next    = (dx != 8'd0) || (dy != 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_byte_reg  <= s1_byte_next;
        s1_first_reg <= s1_first_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        send_reg     <= send_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {dy_reg, dx_reg};
    assign m_tuser  = send_reg;

    // Flag must agree with the deltas it travels with
    `SGMD_ASSERT_IMPL(a_send_matches, clk, rst_n, m_tvalid, m_tuser == ((m_tdata[7:0] != 8'd0) || (m_tdata[15:8] != 8'd0)), "send_report disagrees with deltas")
    // Saturation never yields the most negative code
    `SGMD_ASSERT_IMPL(a_no_neg_128, clk, rst_n, m_tvalid, (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80), "delta outside saturation range")
    // A full pipe with a stalled result takes no input
    `SGMD_ASSERT_IMPL(a_stall_blocks_input, clk, rst_n, s1_valid_reg && m_tvalid && !m_tready, !s_tready, "input taken while pipe is stalled")
    // A parsed sample only comes from a held byte that is moving on
    `SGMD_ASSERT(a_sample_needs_step, clk, rst_n, sample.valid |-> step, "sample without a step")

endmodule

[sim/shtp_gyro_report_to_mouse_delta_unit_tb.sv]
`timescale 1ns / 1ps

module shtp_gyro_report_to_mouse_delta_unit_tb;

    import sgmd_pkg::*;

    localparam int MaxWait       = 17;
    localparam int HoldCycles    = 300;
    localparam int SettleCycles  = 8;
    localparam int TotalBytes    = 1450;
    localparam int WatchdogLimit = 3000;
    localparam int RandomPhases  = 5;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [7:0] dx;
        logic [7:0] dy;
        logic       send;
    } motion_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_addr;
    logic [14:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] first_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] delta_x, [15:8] delta_y
    logic        m_tuser;   // [0] send_report

    // Register copy and parser state of the predictor
    cfg_t        hub_cfg;
    logic [7:0]  pkt_pos;
    logic [7:0]  pkt_len;
    logic [7:0]  len_low;
    logic        pkt_open;
    logic [7:0]  report_pos;
    logic        in_gyro;
    logic [15:0] raw_x;
    logic [7:0]  raw_y_low;

    motion_t motion_q[$];
    int      mismatch_count = 0;
    int      bytes_sent = 0;
    int      idle_cycles = 0;
    int      hold_request = 0;
    bit      no_idle = 1'b0;

    shtp_gyro_report_to_mouse_delta_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Load reset values into the predictor
    function automatic void init_model();
        hub_cfg.sens_x              = SensReset;
        hub_cfg.sens_y              = SensReset;
        hub_cfg.deadband_raw        = DeadbandReset;
        hub_cfg.input_channel       = ChannelReset;
        hub_cfg.gyro_report_id      = GyroIdReset;
        hub_cfg.timestamp_report_id = TsIdReset;
        pkt_pos    = '0;
        pkt_len    = '0;
        len_low    = '0;
        pkt_open   = 1'b0;
        report_pos = FirstReport;
        in_gyro    = 1'b0;
        raw_x      = '0;
        raw_y_low  = '0;
    endfunction

    // Zero below the deadband, scale by sens/512 toward zero, clip to +-127
    function automatic logic [7:0] scale_delta(input logic [15:0] raw16, input logic [3:0] sens);
        int raw;
        int q;
        raw = int'($signed(raw16));
        if ((raw < 0 ? -raw : raw) < int'(hub_cfg.deadband_raw))
            return 8'h00;
        q = raw * int'(sens) / 512;
        if (q > 127)
            return DeltaPosMax;
        if (q < -127)
            return DeltaNegMax;
        return q[7:0];
    endfunction

    // Advance the parser by one byte; return 1 when a movement beat is due
    function automatic bit track_byte(input logic [7:0] b, input logic first,
                                      output motion_t res);
        logic [7:0]  idx;
        logic [7:0]  off;
        logic [14:0] len;
        res = '0;
        if (first)
        begin
            len_low    = b;
            pkt_pos    = 8'd1;
            pkt_open   = 1'b1;
            report_pos = FirstReport;
            in_gyro    = 1'b0;
            pkt_len    = '0;
            return 1'b0;
        end
        if (!pkt_open)
            return 1'b0;
        idx = pkt_pos;
        if (pkt_pos < IndexMax)
            pkt_pos = pkt_pos + 8'd1;

        // header: length, channel, sequence
        if (idx == HdrLenHigh)
        begin
            len = {b[6:0], len_low};
            if (len <= LenMinBad || len == LenReserved)
            begin
                pkt_open = 1'b0;
                return 1'b0;
            end
            if (len > {7'd0, MaxPacket})
                len = {7'd0, MaxPacket};
            if (len < {7'd0, MinPacket})
            begin
                pkt_open = 1'b0;
                return 1'b0;
            end
            pkt_len = len[7:0];
            return 1'b0;
        end
        if (idx == HdrChannel)
        begin
            if (b != hub_cfg.input_channel)
                pkt_open = 1'b0;
            return 1'b0;
        end
        if (idx == HdrSeq)
            return 1'b0;
        if (idx >= pkt_len)
        begin
            pkt_open = 1'b0;
            return 1'b0;
        end

        // report id: skip timestamps, enter the gyro report, stop on anything else
        if (!in_gyro)
        begin
            if (idx != report_pos)
                return 1'b0;
            if (b == hub_cfg.timestamp_report_id)
            begin
                if ({1'b0, report_pos} + TsReportLen >= {1'b0, pkt_len})
                    pkt_open = 1'b0;
                else
                    report_pos = report_pos + TsReportLen[7:0];
            end
            else if (b == hub_cfg.gyro_report_id)
            begin
                if ({1'b0, idx} + GyroLastOff >= {1'b0, pkt_len})
                    pkt_open = 1'b0;
                else
                    in_gyro = 1'b1;
            end
            else
            begin
                pkt_open = 1'b0;
            end
            return 1'b0;
        end

        // gyro report body
        off = idx - report_pos;
        case (off)
            OffXLow:  raw_x = {8'h00, b};
            OffXHigh: raw_x = {b, raw_x[7:0]};
            OffYLow:  raw_y_low = b;
            OffYHigh:
            begin
                res.dx   = scale_delta(raw_x, hub_cfg.sens_x);
                res.dy   = scale_delta({b, raw_y_low}, hub_cfg.sens_y);
                res.send = (res.dx != 8'h00) || (res.dy != 8'h00);
                in_gyro  = 1'b0;
                pkt_open = 1'b0;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic cfg_t cfg_of(input logic [3:0] sx, input logic [3:0] sy,
                                     input logic [14:0] db, input logic [7:0] ch,
                                     input logic [7:0] gid, input logic [7:0] tsid);
        cfg_t c;
        c.sens_x              = sx;
        c.sens_y              = sy;
        c.deadband_raw        = db;
        c.input_channel       = ch;
        c.gyro_report_id      = gid;
        c.timestamp_report_id = tsid;
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        c.sens_x              = 4'($urandom);
        c.sens_y              = 4'($urandom);
        c.deadband_raw        = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                            : 15'($urandom_range(0, 300));
        c.input_channel       = 8'($urandom);
        c.gyro_report_id      = 8'($urandom);
        c.timestamp_report_id = ($urandom_range(0, 9) == 0) ? c.gyro_report_id
                                                            : 8'($urandom);
        return c;
    endfunction

    // Raw axis values weighted toward the deadband and saturation edges
    function automatic logic [15:0] pick_raw();
        logic [15:0] v;
        case ($urandom_range(0, 4))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 600));
            2: v = 16'(int'(hub_cfg.deadband_raw) + int'($urandom_range(0, 4)) - 2);
            3: v = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: v = 16'($urandom_range(0, 32767));
        endcase
        if ($urandom_range(0, 1) != 0)
            v = -v;
        return v;
    endfunction

    // Patch the 15-bit length field; the top bit of byte 1 is random filler
    function automatic byte_q_t with_len(input byte_q_t f, input int len);
        logic [14:0] l;
        l = len[14:0];
        f[0] = l[7:0];
        f[1] = {1'($urandom), l[14:8]};
        return f;
    endfunction

    function automatic byte_q_t with_tail(input byte_q_t f, input int n);
        repeat (n) f.push_back(8'($urandom));
        return f;
    endfunction

    // Well-formed packet: header, n_ts timestamp reports, one gyro report
    function automatic byte_q_t make_frame(input int n_ts, input logic [15:0] x,
                                           input logic [15:0] y);
        byte_q_t f;
        f = {8'h00, 8'h00, hub_cfg.input_channel, 8'($urandom)};
        repeat (n_ts)
        begin
            f.push_back(hub_cfg.timestamp_report_id);
            repeat (4) f.push_back(8'($urandom));
        end
        f.push_back(hub_cfg.gyro_report_id);
        f.push_back(8'($urandom));
        f.push_back(8'($urandom));
        f.push_back(x[7:0]);
        f.push_back(x[15:8]);
        f.push_back(y[7:0]);
        f.push_back(y[15:8]);
        return with_len(f, f.size());
    endfunction

    // Offer one byte after a random gap and predict on acceptance
    task automatic send_byte(input logic [7:0] b, input logic first);
        int      gap;
        motion_t res;
        gap = no_idle ? 0 : $urandom_range(0, MaxWait);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge clk); while (!s_tready);
        if (track_byte(b, first, res))
            motion_q.push_back(res);
        bytes_sent++;
    endtask

    task automatic send_frame(input byte_q_t f);
        int k;
        for (k = 0; k < f.size(); k++)
            send_byte(f[k], k == 0);
    endtask

    // Close any open packet, drop valid, wait out every pending beat
    task automatic settle();
        if (pkt_open)
        begin
            send_byte(8'h00, 1'b1);
            send_byte(8'h00, 1'b0);
        end
        s_tvalid <= 1'b0;
        while (motion_q.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Write all six registers back to back; upper data bits carry filler
    task automatic load_config(input cfg_t c);
        int          i;
        reg_index_t  r;
        logic [14:0] v;
        for (i = REG_SENS_X; i <= REG_TS_ID; i++)
        begin
            r = reg_index_t'(i);
            v = 15'($urandom);
            case (r)
                REG_SENS_X:
                begin
                    v[3:0] = c.sens_x;
                    hub_cfg.sens_x = v[3:0];
                end
                REG_SENS_Y:
                begin
                    v[3:0] = c.sens_y;
                    hub_cfg.sens_y = v[3:0];
                end
                REG_DEADBAND:
                begin
                    v = c.deadband_raw;
                    hub_cfg.deadband_raw = v;
                end
                REG_CHANNEL:
                begin
                    v[7:0] = c.input_channel;
                    hub_cfg.input_channel = v[7:0];
                end
                REG_GYRO_ID:
                begin
                    v[7:0] = c.gyro_report_id;
                    hub_cfg.gyro_report_id = v[7:0];
                end
                REG_TS_ID:
                begin
                    v[7:0] = c.timestamp_report_id;
                    hub_cfg.timestamp_report_id = v[7:0];
                end
                default: ;
            endcase
            cfg_valid <= 1'b1;
            cfg_addr  <= r;
            cfg_data  <= v;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_frame(make_frame(0, 16'h7FFF, 16'h8000));
        send_frame(make_frame(1, 16'd1000, -16'd1000));
        send_frame(make_frame(0, 16'd25, -16'd25));
        settle();
    endtask

    task automatic test_framing_cases();
        byte_q_t f;
        load_config(cfg_of(4'd15, 4'd15, 15'd100, 8'h3C, 8'h11, 8'hA5));
        // deadband edges and truncation toward zero
        send_frame(make_frame(0, 16'd99, -16'd100));
        send_frame(make_frame(2, 16'd100, -16'd99));
        // bad lengths, short packet, gyro report cut off by the length
        send_frame(with_len(make_frame(0, 16'd500, 16'd500), 4));
        send_frame(with_len(make_frame(0, 16'd500, 16'd500), 32'h7FFF));
        send_frame(with_len(make_frame(0, 16'd500, 16'd500), 9));
        send_frame(with_len(make_frame(0, 16'd500, 16'd500), 10));
        // long packet clamps, so a report past the clamp never completes
        send_frame(with_len(make_frame(24, 16'd500, 16'd500), 300));
        // other channel, unknown report id
        f = make_frame(0, 16'd700, 16'd700);
        f[2] = ~f[2];
        send_frame(f);
        f = make_frame(1, 16'd700, 16'd700);
        f[9] = 8'h00;
        send_frame(f);
        // second gyro report after the result, then bytes past the length
        f = make_frame(0, -16'd3000, 16'd3000);
        f.push_back(hub_cfg.gyro_report_id);
        f = with_len(with_tail(f, 6), f.size() + 6);
        send_frame(with_tail(f, 5));
        // stray bytes with no packet open
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // restart in the middle of a gyro report
        f = make_frame(0, 16'd900, 16'd900);
        send_frame(f[0:8]);
        send_frame(make_frame(0, 16'd900, -16'd900));
        settle();
    endtask

    task automatic test_register_extremes();
        load_config(cfg_of(4'd0, 4'd0, 15'd0, 8'hFF, 8'h00, 8'hFF));
        send_frame(make_frame(1, 16'h7FFF, 16'h8000));
        send_frame(make_frame(0, 16'd1, -16'd1));
        settle();
        load_config(cfg_of(4'd15, 4'd15, 15'h7FFF, 8'h00, 8'hFF, 8'h00));
        send_frame(make_frame(0, 16'h8000, 16'h7FFF));
        send_frame(make_frame(1, 16'h7FFE, 16'h8001));
        settle();
    endtask

    // Equal ids: every report is taken as a timestamp and skipped
    task automatic test_id_clash();
        load_config(cfg_of(4'd7, 4'd9, 15'd10, 8'h03, 8'h42, 8'h42));
        send_frame(make_frame(1, 16'd4000, 16'd4000));
        send_frame(make_frame(0, 16'd4000, 16'd4000));
        settle();
    endtask

    // Hold the result side while packets stream in without gaps
    task automatic test_backpressure();
        load_config(cfg_of(4'd9, 4'd3, 15'd20, 8'h5A, 8'h01, 8'hFB));
        no_idle = 1'b1;
        hold_request = HoldCycles;
        repeat (12) send_frame(make_frame($urandom_range(0, 1), pick_raw(), pick_raw()));
        no_idle = 1'b0;
        settle();
    endtask

    task automatic send_random_frame();
        byte_q_t f;
        int      kind;
        int      n_ts;
        kind = $urandom_range(0, 19);
        n_ts = $urandom_range(0, 3);
        f = make_frame(n_ts, pick_raw(), pick_raw());
        f = with_len(f, f.size() + $urandom_range(0, 6));
        case (kind)
            13: f = with_len(f, ($urandom_range(0, 1) != 0) ? 32'h7FFF
                                                            : $urandom_range(0, 4));
            14: f = with_len(f, $urandom_range(5, 9));
            15: f = with_len(f, $urandom);
            16: f[2] = f[2] ^ 8'($urandom_range(1, 255));
            17: f[4 + 5 * n_ts] = 8'($urandom);
            18: f = f[0:$urandom_range(0, f.size() - 2)];
            19:
            begin
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                return;
            end
            default: ;
        endcase
        send_frame(with_tail(f, $urandom_range(0, 3)));
    endtask

    task automatic test_random_traffic();
        int phase;
        int phase_end;
        for (phase = 0; phase < RandomPhases; phase++)
        begin
            if (phase > 0)
                load_config(random_cfg());
            no_idle = (phase == 2);
            phase_end = bytes_sent + (TotalBytes - bytes_sent) / (RandomPhases - phase);
            while (bytes_sent < phase_end)
                send_random_frame();
            settle();
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stall per beat, or a long hold when requested
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = (hold_request > 0) ? hold_request
                                       : (no_idle ? 0 : $urandom_range(0, MaxWait));
            hold_request = 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Compare each result beat with the oldest predicted movement
    always @(posedge clk)
    begin
        motion_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (motion_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat, expected none, got dx=%0d dy=%0d send=%0b",
                         $time, $signed(m_tdata[7:0]), $signed(m_tdata[15:8]), m_tuser);
            end
            else
            begin
                want = motion_q.pop_front();
                if (m_tdata[7:0] !== want.dx)
                begin
                    mismatch_count++;
                    $display("%0t: delta_x expected %0d got %0d", $time,
                             $signed(want.dx), $signed(m_tdata[7:0]));
                end
                if (m_tdata[15:8] !== want.dy)
                begin
                    mismatch_count++;
                    $display("%0t: delta_y expected %0d got %0d", $time,
                             $signed(want.dy), $signed(m_tdata[15:8]));
                end
                if (m_tuser !== want.send)
                begin
                    mismatch_count++;
                    $display("%0t: send_report expected %0b got %0b", $time,
                             want.send, m_tuser);
                end
            end
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_addr  <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        init_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_framing_cases();
        test_register_extremes();
        test_id_clash();
        test_backpressure();
        test_random_traffic();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/sgmd_pkg.sv
sv/sgmd_cfg.sv
sv/sgmd_parser.sv
sv/sgmd_scale.sv
sv/shtp_gyro_report_to_mouse_delta_unit.sv
sim/shtp_gyro_report_to_mouse_delta_unit_tb.sv
